// ----- rtl/wabe_pkg.sv -----
`default_nettype none
package wabe_pkg;

	localparam int unsigned WIN_W = 8;
	localparam int unsigned TOL_W = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PROD_W = WIN_W + DATA_W;
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_TOL = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RELATIVE = 2'd2;

	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 8'd100;
	localparam logic [TOL_W-1:0] DELAY_TOL_RST = 16'd100;
	localparam logic RELATIVE_RST = 1'b0;

	localparam logic [DATA_W-1:0] PERCENT_SCALE = 32'd100;

	typedef struct packed {
		logic [WIN_W-1:0] window_size;
		logic [TOL_W-1:0] delay_tolerance_us;
		logic relative_mode;
	} cfg_t;

	typedef struct packed {
		logic close;
		logic [WIN_W-1:0] below;
		logic [WIN_W-1:0] count;
		logic [DATA_W-1:0] factor;
	} job_t;

endpackage
`default_nettype wire

// ----- rtl/wabe_front.sv -----
`default_nettype none
module wabe_front #(
	parameter int unsigned DELAY_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire wabe_pkg::cfg_t cfg,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire logic [wabe_pkg::DATA_W-1:0] delay_us,
	input wire logic [wabe_pkg::DATA_W-1:0] capacity_kbps,
	input wire logic q_full,
	output logic q_push,
	output wabe_pkg::job_t q_job
);
	import wabe_pkg::*;

	localparam int unsigned DLY_W = (DELAY_WIDTH < DATA_W) ? DELAY_WIDTH : DATA_W;

	logic [WIN_W-1:0] count_q;
	logic [WIN_W-1:0] below_q;
	logic [DLY_W-1:0] min_q;
	logic known_q;

	logic [DLY_W-1:0] delay;
	logic [DLY_W-1:0] min_n;
	logic [WIN_W-1:0] count_n;
	logic [WIN_W-1:0] below_n;
	logic hit;
	logic close;

	assign sample_stall = q_full;
	assign q_push = sample_valid & ~q_full;

	assign delay = delay_us[DLY_W-1:0];
	assign count_n = count_q + 1'b1;
	assign min_n = (!known_q || delay < min_q) ? delay : min_q;
	assign hit = (delay - min_n) < DLY_W'(cfg.delay_tolerance_us);
	assign below_n = below_q + WIN_W'(hit);
	assign close = count_n >= cfg.window_size;

	always_comb begin
		q_job.close = close;
		q_job.below = below_n;
		q_job.count = (count_n == '0) ? WIN_W'(1) : count_n;
		q_job.factor = cfg.relative_mode ? PERCENT_SCALE : capacity_kbps;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			below_q <= '0;
			min_q <= '0;
			known_q <= 1'b0;
		end else if (q_push) begin
			if (close) begin
				count_q <= '0;
				below_q <= '0;
				min_q <= '0;
				known_q <= 1'b0;
			end else begin
				count_q <= count_n;
				below_q <= below_n;
				min_q <= min_n;
				known_q <= 1'b1;
			end
		end
	end

	a_below_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		below_q <= count_q)
		else $error("below count exceeds sample count");
	a_min_known: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> known_q)
		else $error("open window without minimum");
	a_push_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && close) |=> (count_q == '0 && !known_q))
		else $error("window not cleared at close");

endmodule
`default_nettype wire

// ----- rtl/wabe_queue.sv -----
`default_nettype none
module wabe_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire wabe_pkg::job_t wr_job,
	input wire logic pop,
	output wabe_pkg::job_t rd_job,
	output logic empty,
	output logic full
);
	import wabe_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0] fill_q;

	assign empty = (fill_q == '0);
	assign full = (fill_q == (PTR_W+1)'(DEPTH));
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (PTR_W+1)'(DEPTH))
		else $error("queue fill out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(fill_q)))
		else $error("queue pointers disagree with fill");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- rtl/wabe_back.sv -----
`default_nettype none
module wabe_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire wabe_pkg::job_t q_job,
	output logic q_pop,
	output logic result_valid,
	input wire logic result_stall,
	output logic estimate_valid,
	output logic [wabe_pkg::DATA_W-1:0] estimate
);
	import wabe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;
	localparam int unsigned IT_W = $clog2(PROD_W);

	logic [1:0] state_q;
	logic close_q;
	logic [WIN_W-1:0] below_q;
	logic [WIN_W-1:0] count_q;
	logic [DATA_W-1:0] factor_q;
	logic [PROD_W-1:0] prod_q;
	logic [WIN_W-1:0] rem_q;
	logic [IT_W-1:0] iter_q;
	logic out_valid_q;
	logic out_flag_q;
	logic [DATA_W-1:0] out_est_q;

	logic [WIN_W:0] shifted;
	logic [WIN_W:0] diff;
	logic ge;
	logic out_free;

	assign shifted = {rem_q, prod_q[PROD_W-1]};
	assign diff = shifted - {1'b0, count_q};
	assign ge = shifted >= {1'b0, count_q};
	assign out_free = !out_valid_q || !result_stall;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign result_valid = out_valid_q;
	assign estimate_valid = out_flag_q;
	assign estimate = out_est_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					close_q <= q_job.close;
					below_q <= q_job.below;
					count_q <= q_job.count;
					factor_q <= q_job.factor;
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(below_q) * PROD_W'(factor_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], ge};
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_flag_q <= close_q;
			out_est_q <= close_q ? prod_q[DATA_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_job.close ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					iter_q <= IT_W'(PROD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q != '0))
		else $error("divide by zero count");
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && close_q) |-> (prod_q[PROD_W-1:DATA_W] == '0))
		else $error("estimate overflows output width");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < count_q))
		else $error("divider remainder out of range");

endmodule
`default_nettype wire

// ----- rtl/windowed_available_bandwidth_estimate.sv -----
// flow: a sample that leaves the window open goes through pop, then output;
// a sample that closes it goes through pop, one multiply, 40 divide steps, output
// the back end takes a new request only when idle, as it has a single bit-serial
// divider; a 2-entry queue buffers the front side, which stalls while the queue is full
// reset: arst_n clears window state, queue and result_valid; registers load 100, 100, 0
`default_nettype none
module windowed_available_bandwidth_estimate #(
	parameter int unsigned DELAY_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [wabe_pkg::APB_AW-1:0] paddr,
	input wire logic [wabe_pkg::APB_DW-1:0] pwdata,
	output logic [wabe_pkg::APB_DW-1:0] prdata,
	output logic pready,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire logic [wabe_pkg::DATA_W-1:0] delay_us,
	input wire logic [wabe_pkg::DATA_W-1:0] capacity_kbps,
	output logic result_valid,
	input wire logic result_stall,
	output logic estimate_valid,
	output logic [wabe_pkg::DATA_W-1:0] estimate
);
	import wabe_pkg::*;

	cfg_t cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic wr_en;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;
	job_t push_job;
	job_t pop_job;

	assign pready = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= WINDOW_SIZE_RST;
			cfg_q.delay_tolerance_us <= DELAY_TOL_RST;
			cfg_q.relative_mode <= RELATIVE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WINDOW_SIZE: cfg_q.window_size <= pwdata[WIN_W-1:0];
				REG_DELAY_TOL: cfg_q.delay_tolerance_us <= pwdata[TOL_W-1:0];
				REG_RELATIVE: cfg_q.relative_mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_SIZE: prdata = APB_DW'(cfg_q.window_size);
			REG_DELAY_TOL: prdata = APB_DW'(cfg_q.delay_tolerance_us);
			REG_RELATIVE: prdata = APB_DW'(cfg_q.relative_mode);
			default: prdata = '0;
		endcase
	end

	wabe_front #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.delay_us(delay_us),
		.capacity_kbps(capacity_kbps),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(push_job)
	);

	wabe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_job(push_job),
		.pop(q_pop),
		.rd_job(pop_job),
		.empty(q_empty),
		.full(q_full)
	);

	wabe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_job(pop_job),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.estimate_valid(estimate_valid),
		.estimate(estimate)
	);

endmodule
`default_nettype wire
